// ----- rtl/cse_pkg.sv -----
// Shared types, constants and arithmetic helpers for the cubic spline evaluator.
`default_nettype none
package cse_pkg;
    localparam int MAX_KNOTS_DEF = 64;
    localparam int FRAC_BITS_DEF = 16;
    localparam int KCW           = 7;
    localparam int IDXW          = 6;

    localparam logic [1:0] OP_KNOT  = 2'd0;
    localparam logic [1:0] OP_COEFF = 2'd1;
    localparam logic [1:0] OP_EVAL  = 2'd2;

    localparam logic [0:0] REG_KNOT_COUNT = 1'b0;

    // One classified item passed from the front part to the back part.
    typedef struct packed {
        logic [1:0]        opcode;
        logic [IDXW-1:0]   entry_index;
        logic [1:0]        coeff_column;
        logic signed [31:0] data_value;
        logic [2:0]        deriv_order;
    } item_t;

    // Saturate a 34-bit sum to 32 bits signed.
    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        logic signed [33:0] hi;
        logic signed [33:0] lo;
        hi = 34'sh0_7FFF_FFFF;
        lo = -34'sh0_8000_0000;
        if (v > hi) return 32'sh7FFF_FFFF;
        else if (v < lo) return 32'sh8000_0000;
        else return v[31:0];
    endfunction

    // Divide by two, round to nearest, ties away from zero.
    function automatic logic signed [31:0] div2r(input logic signed [31:0] v);
        logic signed [32:0] w;
        logic [32:0] m;
        w = {v[31], v};
        if (!v[31]) return 32'((w + 33'sd1) >>> 1);
        m = 33'(-w);
        m = (m + 33'd1) >> 1;
        return 32'(-$signed(m));
    endfunction

    // Divide by six, round to nearest, ties away from zero (reciprocal multiply).
    // The constant is 2^36 / 6 rounded up, exact for magnitudes below 2^35.
    function automatic logic signed [31:0] div6r(input logic signed [31:0] v);
        logic [32:0] m;
        logic [32:0] q;
        logic [67:0] p;
        m = v[31] ? 33'(-$signed({v[31], v})) : {1'b0, v};
        m = m + 33'd3;
        p = 68'(m) * 68'h2_AAAA_AAAB;
        q = 33'(p >> 36);
        return v[31] ? 32'(-$signed(q)) : q[31:0];
    endfunction
endpackage
`default_nettype wire

// ----- rtl/cse_queue.sv -----
// Short two-entry queue between the front and back parts.
`default_nettype none
module cse_queue
    import cse_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  wr_valid,
    output logic       wr_ready,
    input  wire item_t wr_item,
    output logic       rd_valid,
    input  wire logic  rd_ready,
    output item_t      rd_item
);
    item_t     mem_reg [2];
    logic      wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic      push, pop;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_item  = mem_reg[rptr_reg];
    assign push = wr_valid && wr_ready;
    assign pop  = rd_valid && rd_ready;

    // Pointer and fill count update.
    always_comb
    begin
        wptr_next = push ? ~wptr_reg : wptr_reg;
        rptr_next = pop ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Payload storage.
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= wr_item;
    end
endmodule
`default_nettype wire

// ----- rtl/cse_engine.sv -----
// Back part: table memories, interval search and cubic evaluation.
`default_nettype none
module cse_engine
    import cse_pkg::*;
#(
    parameter int MAX_KNOTS = MAX_KNOTS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic [KCW-1:0]  knot_count,
    input  wire logic            cfg_inval,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire item_t           in_item,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic signed [31:0]   out_value,
    output logic                 out_status,
    output logic [IDXW-1:0]      out_interval
);
    localparam int AW = $clog2(MAX_KNOTS);
    localparam int CW = (AW > IDXW) ? AW + 1 : IDXW + 1;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_RD0   = 10'b0000000010,
        S_CHK   = 10'b0000000100,
        S_SCANR = 10'b0000001000,
        S_SCAN  = 10'b0000010000,
        S_CRD   = 10'b0000100000,
        S_MUL   = 10'b0001000000,
        S_ACC   = 10'b0010000000,
        S_DONE  = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic signed [31:0] knot_mem [MAX_KNOTS];
    logic signed [31:0] c0_mem [MAX_KNOTS];
    logic signed [31:0] c1_mem [MAX_KNOTS];
    logic signed [31:0] c2_mem [MAX_KNOTS];
    logic signed [31:0] c3_mem [MAX_KNOTS];

    logic signed [31:0] ka_reg, kb_reg, c0_reg, c1_reg, c2_reg, c3_reg;
    logic [AW-1:0]      ra_reg, ra_next, rb_reg, rb_next;
    logic               rd_coef;

    item_t              it_reg;
    logic [IDXW-1:0]    civ_reg, civ_next;
    logic               cval_reg, cval_next;
    logic [CW-1:0]      n_act;
    logic [CW-1:0]      scan_reg, scan_next;
    logic [1:0]         step_reg, step_next;
    logic signed [31:0] x0_reg, x0_next;
    logic signed [31:0] h_reg, h_next, acc_reg, acc_next;
    logic signed [31:0] mb_reg, mb_next;
    logic signed [63:0] prod_reg;
    logic signed [31:0] rv_reg, rv_next;
    logic               st_reg, st_next;
    logic [IDXW-1:0]    iv_reg, iv_next;
    logic [AW-1:0]      iva_reg, iva_next;
    logic               wr_en;
    logic signed [31:0] qm;
    logic signed [64:0] pr;

    // Active knot count clamped to the legal range.
    always_comb
    begin
        if (knot_count < KCW'(2))
            n_act = CW'(2);
        else if (CW'(knot_count) > CW'(MAX_KNOTS))
            n_act = CW'(MAX_KNOTS);
        else
            n_act = CW'(knot_count);
    end

    // Rounded, saturated Q product from the product register.
    always_comb
    begin
        pr = {prod_reg[63], prod_reg};
        if (FRAC_BITS > 0)
            pr = pr + (65'sd1 <<< (FRAC_BITS > 0 ? FRAC_BITS - 1 : 0));
        pr = pr >>> FRAC_BITS;
        if (pr > 65'sh0_7FFF_FFFF)
            qm = 32'sh7FFF_FFFF;
        else if (pr < -65'sh0_8000_0000)
            qm = 32'sh8000_0000;
        else
            qm = pr[31:0];
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = (state_reg == S_OUT);
    assign out_value    = rv_reg;
    assign out_status   = st_reg;
    assign out_interval = iv_reg;
    assign wr_en = in_valid && in_ready && (in_item.opcode == OP_KNOT ||
                   in_item.opcode == OP_COEFF) && (32'(in_item.entry_index) < MAX_KNOTS);
    assign rd_coef = (state_reg == S_CRD);

    // Table writes and registered reads.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            if (in_item.opcode == OP_KNOT)
                knot_mem[AW'(in_item.entry_index)] <= in_item.data_value;
            else
            begin
                unique case (in_item.coeff_column)
                    2'd0: c0_mem[AW'(in_item.entry_index)] <= in_item.data_value;
                    2'd1: c1_mem[AW'(in_item.entry_index)] <= in_item.data_value;
                    2'd2: c2_mem[AW'(in_item.entry_index)] <= in_item.data_value;
                    default: c3_mem[AW'(in_item.entry_index)] <= in_item.data_value;
                endcase
            end
        end
        ka_reg <= knot_mem[ra_reg];
        kb_reg <= knot_mem[rb_reg];
        if (rd_coef)
        begin
            c0_reg <= c0_mem[iva_reg];
            c1_reg <= c1_mem[iva_reg];
            c2_reg <= c2_mem[iva_reg];
            c3_reg <= c3_mem[iva_reg];
        end
        prod_reg <= h_reg * mb_reg;
        if (state_reg == S_IDLE && in_valid)
            it_reg <= in_item;
        x0_reg <= x0_next;
        h_reg  <= h_next;
        acc_reg <= acc_next;
        mb_reg <= mb_next;
        rv_reg <= rv_next;
        st_reg <= st_next;
        iv_reg <= iv_next;
        iva_reg <= iva_next;
        scan_reg <= scan_next;
        ra_reg <= ra_next;
        rb_reg <= rb_next;
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        civ_next = civ_reg;
        cval_next = cval_reg;
        ra_next = ra_reg;
        rb_next = rb_reg;
        scan_next = scan_reg;
        step_next = step_reg;
        x0_next = x0_reg;
        h_next = h_reg;
        acc_next = acc_reg;
        mb_next = mb_reg;
        rv_next = rv_reg;
        st_next = st_reg;
        iv_next = iv_reg;
        iva_next = iva_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_item.opcode == OP_EVAL)
                    begin
                        ra_next = AW'(civ_reg);
                        rb_next = AW'(CW'(civ_reg) + CW'(1));
                        state_next = S_RD0;
                    end
                    else if (wr_en)
                        cval_next = 1'b0;
                end
            end
            S_RD0:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (cval_reg && (CW'(civ_reg) + CW'(1) < n_act) &&
                    it_reg.data_value >= ka_reg && it_reg.data_value < kb_reg)
                begin
                    iv_next = civ_reg;
                    iva_next = AW'(civ_reg);
                    x0_next = ka_reg;
                    state_next = S_CRD;
                end
                else
                begin
                    ra_next = '0;
                    rb_next = AW'(n_act - CW'(1));
                    state_next = S_SCANR;
                end
            end
            S_SCANR:
            begin
                // First and last knot arrive in the cycle after their addresses are registered.
                if (step_reg == 2'd0)
                    step_next = 2'd1;
                else
                begin
                    step_next = 2'd0;
                    // Range check against first and last knot.
                    if (it_reg.data_value < ka_reg || it_reg.data_value > kb_reg)
                    begin
                        rv_next = '0;
                        st_next = 1'b1;
                        iv_next = '0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        scan_next = CW'(1);
                        rb_next = AW'(1);
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // Each knot takes a wait step and then a compare step: rb_reg read on the previous edge.
                if (step_reg == 2'd0)
                    step_next = 2'd1;
                else
                begin
                    step_next = 2'd0;
                    if (kb_reg >= it_reg.data_value)
                    begin
                        iv_next = IDXW'(scan_reg - CW'(1));
                        iva_next = AW'(scan_reg - CW'(1));
                        civ_next = IDXW'(scan_reg - CW'(1));
                        cval_next = 1'b1;
                        ra_next = AW'(scan_reg - CW'(1));
                        state_next = S_RD0;
                    end
                    else if (scan_reg + CW'(1) >= n_act)
                    begin
                        iv_next = '0;
                        iva_next = '0;
                        ra_next = '0;
                        state_next = S_RD0;
                    end
                    else
                    begin
                        scan_next = scan_reg + CW'(1);
                        rb_next = AW'(scan_reg + CW'(1));
                    end
                end
                if (state_next == S_RD0)
                begin
                    // Go straight to S_CRD instead of the check: x0 comes from the knot read there.
                    state_next = S_CRD;
                    x0_next = '0;
                    step_next = 2'd3;
                end
            end
            S_CRD:
            begin
                // Coefficients read this edge; knot base may still be loading.
                if (step_reg == 2'd3)
                begin
                    step_next = 2'd2;
                end
                else
                begin
                    if (step_reg == 2'd2)
                        x0_next = ka_reg;
                    h_next = sat34(34'(it_reg.data_value) - 34'(step_reg == 2'd2 ?
                                   ka_reg : x0_reg));
                    step_next = 2'd0;
                    st_next = 1'b0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                // Pick the Horner multiplier operand; order 3 returns c3, above 3 returns zero.
                if (it_reg.deriv_order > 3'd3)
                begin
                    rv_next = '0;
                    state_next = S_OUT;
                end
                else if (it_reg.deriv_order == 3'd3)
                begin
                    rv_next = c3_reg;
                    state_next = S_OUT;
                end
                else
                begin
                    if (step_reg == 2'd0)
                        mb_next = c3_reg;
                    else
                        mb_next = acc_reg;
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // Product of h and operand is in qm now.
                state_next = S_MUL;
                step_next = step_reg + 2'd1;
                if (it_reg.deriv_order == 3'd2)
                begin
                    rv_next = sat34(34'(c2_reg) + 34'(qm));
                    state_next = S_OUT;
                end
                else if (it_reg.deriv_order == 3'd1)
                begin
                    if (step_reg == 2'd0)
                        acc_next = sat34(34'(c2_reg) + 34'(div2r(qm)));
                    else
                    begin
                        rv_next = sat34(34'(c1_reg) + 34'(qm));
                        state_next = S_OUT;
                    end
                end
                else
                begin
                    if (step_reg == 2'd0)
                        acc_next = sat34(34'(div2r(c2_reg)) + 34'(div6r(qm)));
                    else if (step_reg == 2'd1)
                        acc_next = sat34(34'(c1_reg) + 34'(qm));
                    else
                    begin
                        rv_next = sat34(34'(c0_reg) + 34'(qm));
                        state_next = S_OUT;
                    end
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    step_next = 2'd0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (cfg_inval)
            cval_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            civ_reg   <= '0;
            cval_reg  <= 1'b0;
            step_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            civ_reg   <= civ_next;
            cval_reg  <= cval_next;
            step_reg  <= step_next;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/cubic_spline_evaluator_unit.sv -----
// Top level of the cubic spline evaluator: stream ports, register port, front and back.
`default_nettype none
// Piecewise cubic spline evaluator, Q16.16. Write beats (opcode 0 and 1) load knots
// and Taylor coefficients; an evaluate beat (opcode 2) first checks the cached
// interval and on a miss range-checks x against the first and last knot, then walks
// the knots. An x outside the knot range answers zero with status set. Otherwise the
// coefficients are read and the Horner steps run one after another on the shared
// multiplier, fewer of them for higher orders. The knot memory has two read ports.
// The back part takes a new beat only when idle. A two-beat queue sits between input
// and the sequencer. Tables read as undefined until written.
module cubic_spline_evaluator_unit
    import cse_pkg::*;
#(
    parameter int MAX_KNOTS = MAX_KNOTS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // opcode[1:0], entry_index[7:2], coeff_column[9:8], data_value[41:10],
    // deriv_order[44:42], zero fill to 48 bits
    input  wire logic [47:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // result_value[31:0], status[32], interval_used[38:33], zero fill to 40 bits
    output logic [39:0]      m_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    item_t              fi, qi;
    logic               qv, qr;
    logic [KCW-1:0]     kc_reg;
    logic               cfg_wr;
    logic signed [31:0] val;
    logic               stat;
    logic [IDXW-1:0]    ivu;

    // Field unpacking of the input beat.
    always_comb
    begin
        fi.opcode       = s_tdata[1:0];
        fi.entry_index  = s_tdata[7:2];
        fi.coeff_column = s_tdata[9:8];
        fi.data_value   = s_tdata[41:10];
        fi.deriv_order  = s_tdata[44:42];
    end

    // Configuration register.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_KNOT_COUNT);
    assign prdata = (paddr[2] == REG_KNOT_COUNT) ? {25'd0, kc_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            kc_reg <= KCW'(2);
        else if (cfg_wr)
            kc_reg <= pwdata[KCW-1:0];
    end

    cse_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(s_tvalid), .wr_ready(s_tready), .wr_item(fi),
        .rd_valid(qv), .rd_ready(qr), .rd_item(qi)
    );

    cse_engine #(.MAX_KNOTS(MAX_KNOTS), .FRAC_BITS(FRAC_BITS)) u_engine (
        .clk(clk), .rst_n(rst_n),
        .knot_count(kc_reg), .cfg_inval(cfg_wr),
        .in_valid(qv), .in_ready(qr), .in_item(qi),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_value(val), .out_status(stat), .out_interval(ivu)
    );

    assign m_tdata = {1'b0, ivu, stat, val};
endmodule
`default_nettype wire

// ----- rtl/cse_checker.sv -----
// Port-level checker for the cubic spline evaluator, bound to the top level.
`default_nettype none
module cse_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic        pready
);
    // A stalled result beat holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");
    // Out of range results carry value zero and interval zero.
    a_oor: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[32] |-> m_tdata[31:0] == 32'd0 && m_tdata[38:33] == 6'd0)
        else $error("out of range result not cleared");
    // Fill bit stays zero.
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !m_tdata[39])
        else $error("fill bit set");
    a_rdy: assert property (@(posedge clk) pready)
        else $error("pready low");
endmodule

bind cubic_spline_evaluator_unit cse_checker u_cse_checker (
    .clk(clk), .rst_n(rst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .pready(pready)
);
`default_nettype wire
